>>> hw/rtl/slfv_pkg.sv
package slfv_pkg;

  localparam int MAC_ROWS = 24;
  localparam int HDR_READ = 14;
  localparam int POS_W = 9;
  localparam int IDX_W = 5;

  localparam logic [7:0] SYNC_AA = 8'haa;
  localparam logic [7:0] ID_TYPE = 8'h0b;
  localparam logic [7:0] HB_TYPE = 8'h08;
  localparam logic [7:0] TM_HEAD = 8'h6a;
  localparam logic [7:0] TM_TYPE = 8'h0a;
  localparam logic [7:0] TM_MARK = 8'h11;
  localparam logic [7:0] CM_ALT = 8'h6c;
  localparam logic [31:0] ID_CONST = 32'h1b11127f;
  localparam logic [31:0] HB_CONST = 32'haa55aa55;
  localparam logic [15:0] MULT_RESET = 16'd5762;

  localparam logic [IDX_W-1:0] ID_LEN = 5'd13;
  localparam logic [IDX_W-1:0] TM_LEN = 5'd19;
  localparam logic [IDX_W-1:0] HB_LEN = 5'd11;

  localparam logic [47:0] MAC_TABLE [MAC_ROWS] = '{
    48'h0000b40022ee, 48'h0000b400325e, 48'h0048548af0ca, 48'h0048548af0c9,
    48'h0048548af159, 48'h0048548af1e6, 48'h0048548af3c7, 48'h0080c84359ba,
    48'h0080c84359be, 48'h0000b40022e3, 48'h0000b400323e, 48'h0048548af0c1,
    48'h0048548af0c3, 48'h0048548af150, 48'h0048548af1e7, 48'h0048548af3c4,
    48'h0000b40023ee, 48'h0000b400335e, 48'h0048548af1ca, 48'h0048548af1c9,
    48'h0048548af15a, 48'h0048548af1ed, 48'h0048548af3c8, 48'h0080c84359bc
  };

  typedef enum logic [1:0] {K_IDENT, K_TIME, K_HBEAT, K_COMMON} kind_t;

  typedef enum logic [2:0] {
    ST_OK, ST_CONST, ST_MAC, ST_CSUM, ST_UNAUTH, ST_HEADER, ST_SHORT
  } status_t;

  typedef enum logic [1:0] {BK_IDLE, BK_CALC, BK_EMIT} bk_state_t;

  typedef struct packed {
    kind_t           kind;
    status_t         status;
    logic            has_reply;
    logic [9:0][7:0] hdr;
    logic [15:0]     code;
    logic [5:0]      sec;
    logic [5:0]      minute;
    logic [4:0]      hour;
    logic [4:0]      day;
    logic [7:0]      wk;
    logic [6:0]      year;
  } job_t;

  function automatic logic [7:0] week_pack(logic [3:0] month, logic [4:0] day,
                                           logic [2:0] wd);
    logic [2:0] q;
    logic [4:0] r;
    logic [2:0] wd7;
    logic [2:0] wom;
    q = 3'd0;
    r = day;
    if (day >= 5'd28) begin
      q = 3'd4; r = day - 5'd28;
    end else if (day >= 5'd21) begin
      q = 3'd3; r = day - 5'd21;
    end else if (day >= 5'd14) begin
      q = 3'd2; r = day - 5'd14;
    end else if (day >= 5'd7) begin
      q = 3'd1; r = day - 5'd7;
    end
    wd7 = (wd == 3'd0) ? 3'd7 : wd;
    wom = q + (({2'b00, wd7} < r) ? 3'd1 : 3'd0);
    return {month, 4'h0} + {5'b0, wom};
  endfunction

endpackage

>>> hw/rtl/sensor_link_frame_validator.sv
// flow: a frame's last byte writes a job to the queue; its status word, or after
// BK_CALC its reply bytes, one per cycle unless stalled, leave by the output register
// throughput: one received byte per cycle; the input stalls while two frame jobs wait
// in the queue between the byte front end and the reply sequencer
// reset: synchronous; clears framing, authentication, queue and output valid, and
// sets code_multiplier to 5762
module sensor_link_frame_validator #(
  parameter int MAC_ENTRIES = 24,
  parameter int HEADER_KEEP = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  now_year,
  input  logic [3:0]  now_month,
  input  logic [4:0]  now_day,
  input  logic [2:0]  now_weekday,
  input  logic [4:0]  now_hour,
  input  logic [5:0]  now_minute,
  input  logic [5:0]  now_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_kind,
  output logic [2:0]  status,
  output logic [7:0]  reply_byte,
  output logic        reply_valid,
  output logic        last
);
  import slfv_pkg::*;

  logic [15:0] code_multiplier;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  job_t        wr_job;
  job_t        rd_job;

  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_multiplier <= MULT_RESET;
    end else if (cfg_wr_en) begin
      code_multiplier <= cfg_wr_data;
    end
  end

  slfv_front #(
    .MAC_ENTRIES(MAC_ENTRIES),
    .HEADER_KEEP(HEADER_KEEP)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(in_valid && !in_stall),
    .command(command),
    .rx_byte(rx_byte),
    .now_year(now_year),
    .now_month(now_month),
    .now_day(now_day),
    .now_weekday(now_weekday),
    .now_hour(now_hour),
    .now_minute(now_minute),
    .now_second(now_second),
    .push(push),
    .job(wr_job)
  );

  slfv_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_job(wr_job),
    .pop(pop),
    .rd_job(rd_job),
    .full(q_full),
    .empty(q_empty)
  );

  slfv_back u_back (
    .clk(clk),
    .rst(rst),
    .code_multiplier(code_multiplier),
    .rd_job(rd_job),
    .empty(q_empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_kind(frame_kind),
    .status(status),
    .reply_byte(reply_byte),
    .reply_valid(reply_valid),
    .last(last)
  );

`ifndef SYNTHESIS
  a_reply_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |-> status == ST_OK)
    else $error("reply word with bad status");
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply_valid |-> last)
    else $error("status word not marked last");
  a_common_noreply: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == K_COMMON |-> !reply_valid)
    else $error("reply on common frame");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full || pop)
    else $error("job queue overflow");
`endif

endmodule

>>> hw/rtl/slfv_front.sv
module slfv_front #(
  parameter int MAC_ENTRIES = 24,
  parameter int HEADER_KEEP = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          command,
  input  logic [7:0]    rx_byte,
  input  logic [6:0]    now_year,
  input  logic [3:0]    now_month,
  input  logic [4:0]    now_day,
  input  logic [2:0]    now_weekday,
  input  logic [4:0]    now_hour,
  input  logic [5:0]    now_minute,
  input  logic [5:0]    now_second,
  output logic          push,
  output slfv_pkg::job_t job
);
  import slfv_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] frame_total;
  logic [7:0]       running_xor;
  logic [7:0]       first_byte_xor;
  logic             authenticated;
  logic [7:0]       header_bytes [HEADER_KEEP];

  logic [7:0]       hn [HDR_READ];
  logic [POS_W-1:0] ft_eff;
  logic             frame_end;
  logic             mac_hit;
  logic [7:0]       x_all;
  logic [7:0]       x_skip;
  logic             set_auth;

  always_comb begin
    for (int i = 0; i < HDR_READ; i++) begin
      hn[i] = (byte_position == POS_W'(i)) ? rx_byte : header_bytes[i];
    end
  end

  assign ft_eff = (byte_position == POS_W'(1)) ? (POS_W'(rx_byte) + POS_W'(3)) : frame_total;
  assign frame_end = (byte_position != '0) &&
                     ({1'b0, byte_position} + 10'd1 == {1'b0, ft_eff});
  assign x_all = running_xor;
  assign x_skip = running_xor ^ first_byte_xor;

  always_comb begin
    mac_hit = 1'b0;
    for (int i = 0; i < MAC_ROWS; i++) begin
      if (i < MAC_ENTRIES &&
          {hn[6], hn[7], hn[8], hn[9], hn[10], hn[11]} == MAC_TABLE[i]) begin
        mac_hit = 1'b1;
      end
    end
  end

  always_comb begin
    job.kind = K_COMMON;
    job.status = ST_OK;
    job.has_reply = 1'b0;
    set_auth = 1'b0;
    for (int i = 0; i < 10; i++) begin
      job.hdr[i] = hn[i+2];
    end
    job.code = {hn[13], hn[12]};
    job.sec = now_second;
    job.minute = now_minute;
    job.hour = now_hour;
    job.day = now_day;
    job.wk = week_pack(now_month, now_day, now_weekday);
    job.year = now_year;
    priority if (hn[0] == SYNC_AA && hn[1] == ID_TYPE) begin
      job.kind = K_IDENT;
      priority if ({hn[2], hn[3], hn[4], hn[5]} != ID_CONST) begin
        job.status = ST_CONST;
      end else if (!mac_hit) begin
        job.status = ST_MAC;
      end else if (x_all != rx_byte) begin
        job.status = ST_CSUM;
      end else begin
        job.has_reply = 1'b1;
        set_auth = 1'b1;
      end
    end else if (hn[0] == TM_HEAD && hn[1] == TM_TYPE && hn[6] == TM_MARK) begin
      job.kind = K_TIME;
      if (x_skip != rx_byte) begin
        job.status = ST_CSUM;
      end else begin
        job.has_reply = 1'b1;
      end
    end else if (hn[0] == SYNC_AA && hn[1] == HB_TYPE &&
                 {hn[2], hn[3], hn[4], hn[5]} == HB_CONST) begin
      job.kind = K_HBEAT;
      if (x_all != rx_byte) begin
        job.status = ST_CSUM;
      end else begin
        job.has_reply = 1'b1;
      end
    end else begin
      priority if (!authenticated) begin
        job.status = ST_UNAUTH;
      end else if (hn[0] != TM_HEAD && hn[0] != CM_ALT) begin
        job.status = ST_HEADER;
      end else if (frame_total == POS_W'(3)) begin
        job.status = ST_SHORT;
      end else if (x_skip != rx_byte) begin
        job.status = ST_CSUM;
      end
    end
  end

  assign push = take && !command && frame_end;

  always_ff @(posedge clk) begin
    if (take && !command) begin
      for (int i = 0; i < HEADER_KEEP; i++) begin
        if (byte_position == POS_W'(i)) begin
          header_bytes[i] <= rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_total <= '0;
      running_xor <= '0;
      first_byte_xor <= '0;
      authenticated <= 1'b0;
    end else if (take) begin
      if (command) begin
        byte_position <= '0;
        frame_total <= '0;
        running_xor <= '0;
        first_byte_xor <= '0;
        authenticated <= 1'b0;
      end else begin
        if (byte_position == '0) begin
          first_byte_xor <= rx_byte;
        end
        if (byte_position == POS_W'(1)) begin
          frame_total <= ft_eff;
        end
        if (frame_end) begin
          byte_position <= '0;
          running_xor <= '0;
          if (set_auth) begin
            authenticated <= 1'b1;
          end
        end else begin
          running_xor <= running_xor ^ rx_byte;
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end
  end

endmodule

>>> hw/rtl/slfv_queue.sv
module slfv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slfv_pkg::job_t wr_job,
  input  logic           pop,
  output slfv_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);
  import slfv_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

endmodule

>>> hw/rtl/slfv_back.sv
module slfv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    code_multiplier,
  input  slfv_pkg::job_t rd_job,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     frame_kind,
  output logic [2:0]     status,
  output logic [7:0]     reply_byte,
  output logic           reply_valid,
  output logic           last
);
  import slfv_pkg::*;

  bk_state_t        state, state_next;
  job_t             cur, cur_next;
  logic [31:0]      cal;
  logic [IDX_W-1:0] idx, idx_next;
  logic [7:0]       crc, crc_next;
  logic             out_free;
  logic             load;
  logic [1:0]       kind_d;
  logic [2:0]       status_d;
  logic [7:0]       byte_d;
  logic             rvalid_d;
  logic             last_d;
  logic [IDX_W-1:0] len;
  logic             crc_use;
  logic [7:0]       body;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cur.kind)
      K_IDENT: len = ID_LEN;
      K_TIME:  len = TM_LEN;
      default: len = HB_LEN;
    endcase
    crc_use = (cur.kind == K_TIME) ? (idx != '0) : 1'b1;
    body = 8'h00;
    unique case (cur.kind)
      K_IDENT: begin
        unique case (idx)
          5'd0:    body = 8'h55;
          5'd1:    body = 8'h0a;
          5'd2:    body = 8'h1b;
          5'd3:    body = 8'h11;
          5'd4:    body = 8'h12;
          5'd5:    body = cal[23:16];
          5'd6:    body = cal[15:8];
          5'd7:    body = 8'h7f;
          5'd9:    body = cal[7:0];
          5'd10:   body = cal[31:24];
          default: body = 8'h00;
        endcase
      end
      K_TIME: begin
        unique case (idx)
          5'd0:    body = 8'h66;
          5'd1:    body = 8'h10;
          5'd2:    body = cur.hdr[0];
          5'd3:    body = cur.hdr[1];
          5'd4:    body = cur.hdr[2];
          5'd5:    body = cur.hdr[3];
          5'd6:    body = 8'h14;
          5'd7:    body = cur.hdr[5];
          5'd8:    body = cur.hdr[6];
          5'd9:    body = cur.hdr[7];
          5'd10:   body = cur.hdr[8];
          5'd11:   body = cur.hdr[9];
          5'd12:   body = {2'b00, cur.sec};
          5'd13:   body = {2'b00, cur.minute};
          5'd14:   body = {3'b000, cur.hour};
          5'd15:   body = {3'b000, cur.day};
          5'd16:   body = cur.wk;
          5'd17:   body = {1'b0, cur.year};
          default: body = 8'h00;
        endcase
      end
      K_HBEAT: begin
        unique case (idx)
          5'd0:    body = 8'h55;
          5'd1:    body = 8'h08;
          5'd2:    body = 8'h55;
          5'd3:    body = 8'haa;
          5'd4:    body = 8'h55;
          5'd5:    body = 8'haa;
          5'd6:    body = cur.hdr[4];
          5'd7:    body = cur.hdr[5];
          5'd8:    body = cur.hdr[6];
          5'd9:    body = cur.hdr[7];
          default: body = 8'h00;
        endcase
      end
      default: body = 8'h00;
    endcase
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    idx_next = idx;
    crc_next = crc;
    pop = 1'b0;
    load = 1'b0;
    kind_d = cur.kind;
    status_d = ST_OK;
    byte_d = 8'h00;
    rvalid_d = 1'b0;
    last_d = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          if (rd_job.has_reply) begin
            cur_next = rd_job;
            state_next = BK_CALC;
          end else begin
            load = 1'b1;
            kind_d = rd_job.kind;
            status_d = rd_job.status;
          end
        end
      end
      BK_CALC: begin
        idx_next = '0;
        crc_next = '0;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          rvalid_d = 1'b1;
          last_d = (idx == len - IDX_W'(1));
          byte_d = last_d ? crc : body;
          if (crc_use) begin
            crc_next = crc ^ body;
          end
          idx_next = idx + IDX_W'(1);
          if (last_d) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    crc <= crc_next;
    if (state == BK_CALC) begin
      cal <= 32'(code_multiplier * cur.code);
    end
    if (load) begin
      frame_kind <= kind_d;
      status <= status_d;
      reply_byte <= byte_d;
      reply_valid <= rvalid_d;
      last <= last_d;
    end
  end

endmodule

>>> dv/tb_sensor_link_frame_validator.sv
`timescale 1ns / 1ps

module tb_sensor_link_frame_validator;
  import slfv_pkg::*;

  typedef enum int {F_IDENT, F_TIME, F_HBEAT, F_COMMON, F_NEWCONN} frame_sel_t;
  typedef enum int {FL_NONE, FL_CONST, FL_MAC, FL_CSUM, FL_SHORT} flaw_t;
  typedef enum int {TM_RAND, TM_MAX, TM_ZERO} clock_mode_t;

  typedef struct {
    kind_t      kind;
    status_t    st;
    logic [7:0] data;
    logic       rv;
    logic       lst;
  } word_t;

  typedef struct {
    frame_sel_t  sel;
    flaw_t       flaw;
    logic [7:0]  b0;
    logic [7:0]  code_lo;
    clock_mode_t tmode;
    bit          typed;
    kind_t       exp_kind;
    status_t     exp_st;
  } recipe_t;

  logic        clk, rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid, in_stall;
  logic        command;
  logic [7:0]  rx_byte;
  logic [6:0]  now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_day;
  logic [2:0]  now_weekday;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;
  logic [5:0]  now_second;
  logic        out_valid, out_stall;
  logic [1:0]  frame_kind;
  logic [2:0]  status;
  logic [7:0]  reply_byte;
  logic        reply_valid;
  logic        last;

  sensor_link_frame_validator uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
    .now_year(now_year), .now_month(now_month), .now_day(now_day),
    .now_weekday(now_weekday), .now_hour(now_hour), .now_minute(now_minute),
    .now_second(now_second), .out_valid(out_valid), .out_stall(out_stall),
    .frame_kind(frame_kind), .status(status), .reply_byte(reply_byte),
    .reply_valid(reply_valid), .last(last)
  );

  // predictor state
  logic [15:0] mult;
  logic [8:0]  pos, total;
  logic [7:0]  rxor, first_b;
  logic [7:0]  hdr [14];
  logic        auth;

  word_t       due_words [$];
  logic [7:0]  frame_q [$];
  int          errors, items_sent;
  int          send_pct, recv_pct;
  clock_mode_t tmode;
  bit          head_seen;
  kind_t       head_kind;
  status_t     head_st;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < recv_pct);

  task automatic push_word(kind_t k, status_t s, logic [7:0] d, logic v, logic l);
    word_t w;
    w.kind = k; w.st = s; w.data = d; w.rv = v; w.lst = l;
    if (!head_seen) begin
      head_seen = 1; head_kind = k; head_st = s;
    end
    due_words.push_back(w);
  endtask

  task automatic push_reply(kind_t k, logic [7:0] rep [19], int n, int from);
    logic [7:0] c;
    c = 0;
    for (int i = from; i < n - 1; i++) c ^= rep[i];
    rep[n-1] = c;
    for (int i = 0; i < n; i++) push_word(k, ST_OK, rep[i], 1'b1, i == n - 1);
  endtask

  function automatic bit mac_listed();
    for (int i = 0; i < MAC_ROWS; i++)
      if ({hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]} == MAC_TABLE[i]) return 1;
    return 0;
  endfunction

  task automatic judge_frame(logic [7:0] lastb);
    logic [7:0]  rep [19];
    logic [7:0]  x_all, x_skip;
    logic [31:0] cal;
    logic [2:0]  wd7;
    logic [7:0]  wom;
    x_all = rxor;
    x_skip = rxor ^ first_b;
    foreach (rep[i]) rep[i] = 0;
    if (hdr[0] == SYNC_AA && hdr[1] == ID_TYPE) begin
      if ({hdr[2], hdr[3], hdr[4], hdr[5]} != ID_CONST)
        push_word(K_IDENT, ST_CONST, 0, 0, 1);
      else if (!mac_listed()) push_word(K_IDENT, ST_MAC, 0, 0, 1);
      else if (x_all != lastb) push_word(K_IDENT, ST_CSUM, 0, 0, 1);
      else begin
        cal = 32'(mult) * 32'({hdr[13], hdr[12]});
        rep[0] = 8'h55; rep[1] = 8'h0a; rep[2] = 8'h1b; rep[3] = 8'h11;
        rep[4] = 8'h12; rep[5] = cal[23:16]; rep[6] = cal[15:8]; rep[7] = 8'h7f;
        rep[8] = 8'h00; rep[9] = cal[7:0]; rep[10] = cal[31:24]; rep[11] = 8'h00;
        auth = 1;
        push_reply(K_IDENT, rep, 13, 0);
      end
    end else if (hdr[0] == TM_HEAD && hdr[1] == TM_TYPE && hdr[6] == TM_MARK) begin
      if (x_skip != lastb) push_word(K_TIME, ST_CSUM, 0, 0, 1);
      else begin
        wd7 = (now_weekday == 0) ? 3'd7 : now_weekday;
        wom = 8'(now_day / 7) + ((5'(wd7) < now_day % 7) ? 8'd1 : 8'd0);
        rep[0] = 8'h66; rep[1] = 8'h10;
        for (int i = 2; i < 6; i++) rep[i] = hdr[i];
        rep[6] = 8'h14;
        for (int i = 7; i < 12; i++) rep[i] = hdr[i];
        rep[12] = 8'(now_second);
        rep[13] = 8'(now_minute);
        rep[14] = 8'(now_hour);
        rep[15] = 8'(now_day);
        rep[16] = {now_month, 4'h0} + wom;
        rep[17] = 8'(now_year);
        push_reply(K_TIME, rep, 19, 1);
      end
    end else if (hdr[0] == SYNC_AA && hdr[1] == HB_TYPE &&
                 {hdr[2], hdr[3], hdr[4], hdr[5]} == HB_CONST) begin
      if (x_all != lastb) push_word(K_HBEAT, ST_CSUM, 0, 0, 1);
      else begin
        rep[0] = 8'h55; rep[1] = 8'h08; rep[2] = 8'h55; rep[3] = 8'haa;
        rep[4] = 8'h55; rep[5] = 8'haa;
        for (int i = 6; i < 10; i++) rep[i] = hdr[i];
        push_reply(K_HBEAT, rep, 11, 0);
      end
    end else if (!auth) push_word(K_COMMON, ST_UNAUTH, 0, 0, 1);
    else if (hdr[0] != TM_HEAD && hdr[0] != CM_ALT) push_word(K_COMMON, ST_HEADER, 0, 0, 1);
    else if (total < 4) push_word(K_COMMON, ST_SHORT, 0, 0, 1);
    else if (x_skip != lastb) push_word(K_COMMON, ST_CSUM, 0, 0, 1);
    else push_word(K_COMMON, ST_OK, 0, 0, 1);
  endtask

  task automatic track_rx_byte();
    logic [7:0] b;
    b = rx_byte;
    if (command) begin
      pos = 0; total = 0; rxor = 0; first_b = 0; auth = 0;
      return;
    end
    if (pos < 14) hdr[pos] = b;
    if (pos == 0) first_b = b;
    if (pos == 1) total = 9'(b) + 9'd3;
    if (pos >= 1 && pos + 9'd1 == total) begin
      judge_frame(b);
      pos = 0; rxor = 0;
    end else begin
      rxor ^= b;
      pos = pos + 9'd1;
    end
  endtask

  task automatic send_item(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    command = cmd;
    rx_byte = b;
    case (tmode)
      TM_MAX: begin
        now_year = '1; now_month = '1; now_day = '1; now_weekday = '1;
        now_hour = '1; now_minute = '1; now_second = '1;
      end
      TM_ZERO: begin
        now_year = 0; now_month = 0; now_day = 0; now_weekday = 0;
        now_hour = 0; now_minute = 0; now_second = 0;
      end
      default: begin
        now_year = $urandom_range(127); now_month = $urandom_range(15);
        now_day = $urandom_range(31); now_weekday = $urandom_range(7);
        now_hour = $urandom_range(31); now_minute = $urandom_range(63);
        now_second = $urandom_range(63);
      end
    endcase
    do @(posedge clk); while (in_stall);
    track_rx_byte();
    items_sent++;
    @(negedge clk);
  endtask

  task automatic build_frame(recipe_t r);
    logic [47:0] mac;
    logic [7:0]  c;
    int          len;
    frame_q.delete();
    case (r.sel)
      F_IDENT: begin
        mac = MAC_TABLE[$urandom_range(MAC_ROWS - 1)];
        frame_q = '{SYNC_AA, ID_TYPE, ID_CONST[31:24], ID_CONST[23:16],
                    ID_CONST[15:8], ID_CONST[7:0]};
        for (int i = 5; i >= 0; i--) frame_q.push_back(mac[i*8 +: 8]);
        frame_q.push_back(r.code_lo);
        if (r.flaw == FL_CONST) frame_q[2 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
        if (r.flaw == FL_MAC) frame_q[6] = 8'($urandom_range(1, 255));
      end
      F_TIME: begin
        frame_q = '{TM_HEAD, TM_TYPE};
        for (int i = 2; i < 12; i++) frame_q.push_back(i == 6 ? TM_MARK : 8'($urandom));
      end
      F_HBEAT: begin
        frame_q = '{SYNC_AA, HB_TYPE, HB_CONST[31:24], HB_CONST[23:16],
                    HB_CONST[15:8], HB_CONST[7:0]};
        repeat (4) frame_q.push_back(8'($urandom));
        if (r.flaw == FL_CONST) frame_q[2 + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
      end
      default: begin
        do len = $urandom_range(16); while (len == 8 || len == 10 || len == 11);
        if (r.flaw == FL_SHORT) len = 0;
        frame_q = '{r.b0, 8'(len)};
        repeat (len) frame_q.push_back(8'($urandom));
      end
    endcase
    c = 0;
    for (int i = (r.sel == F_IDENT || r.sel == F_HBEAT) ? 0 : 1; i < frame_q.size(); i++)
      c ^= frame_q[i];
    if (r.flaw == FL_CSUM) c ^= 8'($urandom_range(1, 255));
    frame_q.push_back(c);
  endtask

  task automatic run_recipe(recipe_t r);
    tmode = r.tmode;
    head_seen = 0;
    if (r.sel == F_NEWCONN) send_item(1'b1, 8'($urandom));
    else begin
      build_frame(r);
      foreach (frame_q[i]) send_item(1'b0, frame_q[i]);
    end
    if (r.typed && (!head_seen || head_kind != r.exp_kind || head_st != r.exp_st)) begin
      $error("directed row: frame_kind expected %0d actual %0d, status expected %0d actual %0d",
             r.exp_kind, head_kind, r.exp_st, head_st);
      errors++;
    end
  endtask

  task automatic write_multiplier(logic [15:0] v);
    in_valid = 0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 0;
    mult = v;
  endtask

  task automatic random_step();
    recipe_t r;
    int      pick, n;
    r.typed = 0; r.tmode = TM_RAND; r.flaw = FL_NONE;
    r.code_lo = 8'($urandom); r.b0 = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) begin
      r.sel = frame_sel_t'($urandom_range(3));
      if (r.sel == F_COMMON) begin
        n = $urandom_range(2);
        r.b0 = (n == 0) ? TM_HEAD : (n == 1) ? CM_ALT : 8'($urandom);
      end
      if ($urandom_range(99) < 20) r.flaw = flaw_t'($urandom_range(1, 4));
      if (r.sel == F_IDENT && $urandom_range(9) == 0) r.code_lo = $urandom_range(1) ? 8'hff : 8'h00;
      run_recipe(r);
    end else if (pick < 85) begin
      r.sel = F_NEWCONN;
      run_recipe(r);
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom));
      if ($urandom_range(9) < 8) send_item(1'b1, 8'($urandom));
    end else begin
      r.sel = frame_sel_t'($urandom_range(3));
      build_frame(r);
      n = $urandom_range(1, frame_q.size() - 1);
      for (int i = 0; i < n; i++) send_item(1'b0, frame_q[i]);
      send_item(1'b1, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: kind %0d status %0d byte %02h", frame_kind, status, reply_byte);
        errors++;
      end else begin
        word_t w;
        w = due_words.pop_front();
        if (frame_kind != w.kind) begin
          $error("frame_kind expected %0d actual %0d", w.kind, frame_kind); errors++;
        end
        if (status != w.st) begin
          $error("status expected %0d actual %0d", w.st, status); errors++;
        end
        if (reply_byte != w.data) begin
          $error("reply_byte expected %02h actual %02h", w.data, reply_byte); errors++;
        end
        if (reply_valid != w.rv) begin
          $error("reply_valid expected %0d actual %0d", w.rv, reply_valid); errors++;
        end
        if (last != w.lst) begin
          $error("last expected %0d actual %0d", w.lst, last); errors++;
        end
      end
    end
  end

  recipe_t directed [] = '{
    '{F_COMMON, FL_NONE,  TM_HEAD, 8'h00, TM_RAND, 1, K_COMMON, ST_UNAUTH},
    '{F_HBEAT,  FL_NONE,  8'h00,   8'h00, TM_RAND, 1, K_HBEAT,  ST_OK},
    '{F_HBEAT,  FL_CSUM,  8'h00,   8'h00, TM_RAND, 1, K_HBEAT,  ST_CSUM},
    '{F_TIME,   FL_CSUM,  8'h00,   8'h00, TM_RAND, 1, K_TIME,   ST_CSUM},
    '{F_TIME,   FL_NONE,  8'h00,   8'h00, TM_RAND, 1, K_TIME,   ST_OK},
    '{F_IDENT,  FL_CONST, 8'h00,   8'h00, TM_RAND, 1, K_IDENT,  ST_CONST},
    '{F_IDENT,  FL_MAC,   8'h00,   8'h00, TM_RAND, 1, K_IDENT,  ST_MAC},
    '{F_IDENT,  FL_CSUM,  8'h00,   8'h00, TM_RAND, 1, K_IDENT,  ST_CSUM},
    '{F_IDENT,  FL_NONE,  8'h00,   8'h00, TM_RAND, 1, K_IDENT,  ST_OK},
    '{F_IDENT,  FL_NONE,  8'h00,   8'hff, TM_RAND, 1, K_IDENT,  ST_OK},
    '{F_COMMON, FL_NONE,  8'h00,   8'h00, TM_RAND, 1, K_COMMON, ST_HEADER},
    '{F_COMMON, FL_NONE,  8'hff,   8'h00, TM_RAND, 1, K_COMMON, ST_HEADER},
    '{F_COMMON, FL_SHORT, TM_HEAD, 8'h00, TM_RAND, 1, K_COMMON, ST_SHORT},
    '{F_COMMON, FL_NONE,  CM_ALT,  8'h00, TM_RAND, 1, K_COMMON, ST_OK},
    '{F_COMMON, FL_CSUM,  TM_HEAD, 8'h00, TM_RAND, 1, K_COMMON, ST_CSUM},
    '{F_HBEAT,  FL_CONST, 8'h00,   8'h00, TM_RAND, 1, K_COMMON, ST_HEADER},
    '{F_TIME,   FL_NONE,  8'h00,   8'h00, TM_MAX,  0, K_TIME,   ST_OK},
    '{F_TIME,   FL_NONE,  8'h00,   8'h00, TM_ZERO, 0, K_TIME,   ST_OK},
    '{F_NEWCONN, FL_NONE, 8'h00,   8'h00, TM_RAND, 0, K_COMMON, ST_OK},
    '{F_COMMON, FL_NONE,  TM_HEAD, 8'h00, TM_RAND, 1, K_COMMON, ST_UNAUTH}
  };

  initial begin
    int target;
    int share;
    rst = 1; cfg_wr_en = 0; cfg_wr_data = 0; in_valid = 0; command = 0; rx_byte = 0;
    now_year = 0; now_month = 0; now_day = 0; now_weekday = 0;
    now_hour = 0; now_minute = 0; now_second = 0;
    errors = 0; items_sent = 0; send_pct = 30; recv_pct = 60; tmode = TM_RAND;
    mult = MULT_RESET; pos = 0; total = 0; rxor = 0; first_b = 0; auth = 0;
    foreach (hdr[i]) hdr[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (directed[i]) run_recipe(directed[i]);

    share = (430 - items_sent) / 3;
    target = items_sent;
    write_multiplier(16'h0000);
    target += share;
    while (items_sent < target) random_step();

    write_multiplier(16'hffff);
    send_pct = 60; recv_pct = 30;
    target += share;
    while (items_sent < target) random_step();

    write_multiplier(16'($urandom));
    send_pct = 0; recv_pct = 0;
    target = 430;
    while (items_sent < target) random_step();

    in_valid = 0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slfv_pkg.sv
hw/rtl/slfv_front.sv
hw/rtl/slfv_queue.sv
hw/rtl/slfv_back.sv
hw/rtl/sensor_link_frame_validator.sv
dv/tb_sensor_link_frame_validator.sv
